>>> hw/rtl/mrrb_pkg.sv
// types, constants and the fixed-point scale helper for the mask row run box extractor
package mrrb_pkg;

    localparam int MAX_WIDTH  = 1024;
    localparam int MAX_HEIGHT = 1024;
    localparam int COL_W      = $clog2(MAX_WIDTH);
    localparam int ROW_W      = $clog2(MAX_HEIGHT);

    localparam int SIZE_W  = 11;
    localparam int STEP_W  = 17;
    localparam int SCALE_W = 11;
    localparam int PROD_W  = SCALE_W + STEP_W;

    localparam logic [STEP_W-1:0] Q_ONE = 17'h10000;

    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 17;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_MASK_WIDTH  = 2'd0,
        REG_MASK_HEIGHT = 2'd1,
        REG_COLUMN_STEP = 2'd2,
        REG_ROW_STEP    = 2'd3
    } t_cfg_reg;

    typedef struct packed {
        logic [7:0]  pixel;
        logic [15:0] mask_label;
        logic [10:0] mask_id;
    } t_pixel_beat;

    typedef struct packed {
        logic [16:0] y_min;
        logic [16:0] x_min;
        logic [16:0] y_max;
        logic [16:0] x_max;
        logic [15:0] box_label;
        logic [10:0] box_id;
    } t_box_beat;

    // clamp a size register into 1..max and return max index (size minus one)
    function automatic logic [COL_W-1:0] last_col_idx(input logic [SIZE_W-1:0] v);
        logic [SIZE_W-1:0] c;
        c = v;
        if (v == '0) begin
            c = SIZE_W'(1);
        end else if (v > SIZE_W'(MAX_WIDTH)) begin
            c = SIZE_W'(MAX_WIDTH);
        end
        return COL_W'(c - SIZE_W'(1));
    endfunction

    function automatic logic [ROW_W-1:0] last_row_idx(input logic [SIZE_W-1:0] v);
        logic [SIZE_W-1:0] c;
        c = v;
        if (v == '0) begin
            c = SIZE_W'(1);
        end else if (v > SIZE_W'(MAX_HEIGHT)) begin
            c = SIZE_W'(MAX_HEIGHT);
        end
        return ROW_W'(c - SIZE_W'(1));
    endfunction

    // exact product, saturated at 1.0
    function automatic logic [STEP_W-1:0] q_scale(
        input logic [SCALE_W-1:0] n,
        input logic [STEP_W-1:0]  step
    );
        logic [PROD_W-1:0] p;
        p = PROD_W'(n) * PROD_W'(step);
        return (p > PROD_W'(Q_ONE)) ? Q_ONE : p[STEP_W-1:0];
    endfunction

endpackage

>>> hw/rtl/mask_row_run_boxes.sv
// mask row run box extractor: run tracking stage and box scaling stage
//
// Pixels of binary masks enter in raster order on the pixel channel, one
// beat per pixel (i_valid / o_stall). A nonzero pixel is set. Each time a
// horizontal run of set pixels ends, at a zero pixel or at the last column,
// one box beat leaves on the box channel (o_valid / i_stall) with the row
// and column bounds as Q1.16 fractions and the label and id of the pixel
// that closed the run. Pixels that close no run produce nothing.
// Registers (width, height, column and row step) are written on the cfg
// channel, which is always ready; write them only while no box is pending.
// A box closed by a pixel beat passes the run tracking register, then the
// multiply and saturate register.
// Throughput: one pixel per cycle while o_stall is low, set by the run loop.
// A box waiting under stall does not block intake: one more closing pixel is
// held in the tracking register before o_stall rises.
// Reset clears the counters, the run flag and both valid flags, and loads
// width and height 1024 and steps 64.
module mask_row_run_boxes (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_valid,
    output logic                                o_stall,
    input  mrrb_pkg::t_pixel_beat               i_pix,
    output logic                                o_valid,
    input  logic                                i_stall,
    output mrrb_pkg::t_box_beat                 o_box,
    input  logic                                i_cfg_valid,
    output logic                                o_cfg_ready,
    input  logic [mrrb_pkg::CFG_IDX_W-1:0]      i_cfg_index,
    input  logic [mrrb_pkg::CFG_DATA_W-1:0]     i_cfg_data
);
    import mrrb_pkg::*;

    logic [SIZE_W-1:0] r_mask_width, r_mask_height;
    logic [STEP_W-1:0] r_column_step, r_row_step;

    logic [COL_W-1:0]  r_col, n_col;
    logic [ROW_W-1:0]  r_row, n_row;
    logic              r_in_run, n_in_run;
    logic [COL_W-1:0]  r_run_start, n_run_start;

    // run tracking register
    logic              r_s1_valid;
    logic [ROW_W-1:0]  r_s1_row;
    logic [COL_W-1:0]  r_s1_start;
    logic [COL_W-1:0]  r_s1_end;
    logic              r_s1_edge;
    logic [15:0]       r_s1_label;
    logic [10:0]       r_s1_id;

    logic              r_out_valid;
    t_box_beat         r_out;

    logic              accept, pix_set, last_col, last_row, emit, out_ready, s1_move;
    logic [COL_W-1:0]  box_start;

    assign o_cfg_ready = 1'b1;

    assign out_ready = !r_out_valid || !i_stall;
    assign s1_move   = r_s1_valid && out_ready;
    assign o_stall   = r_s1_valid && !out_ready;
    assign accept    = i_valid && !o_stall;

    assign pix_set   = i_pix.pixel != '0;
    assign last_col  = r_col >= last_col_idx(r_mask_width);
    assign last_row  = r_row >= last_row_idx(r_mask_height);
    assign box_start = (pix_set && !r_in_run) ? r_col : r_run_start;
    assign emit      = pix_set ? last_col : r_in_run;

    always_comb begin
        n_run_start = box_start;
        n_in_run    = pix_set && !last_col;
        if (last_col) begin
            n_col = '0;
            n_row = last_row ? '0 : r_row + ROW_W'(1);
        end else begin
            n_col = r_col + COL_W'(1);
            n_row = r_row;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mask_width  <= SIZE_W'(MAX_WIDTH);
            r_mask_height <= SIZE_W'(MAX_HEIGHT);
            r_column_step <= STEP_W'(64);
            r_row_step    <= STEP_W'(64);
        end else if (i_cfg_valid && o_cfg_ready) begin
            unique case (t_cfg_reg'(i_cfg_index))
                REG_MASK_WIDTH:  r_mask_width  <= i_cfg_data[SIZE_W-1:0];
                REG_MASK_HEIGHT: r_mask_height <= i_cfg_data[SIZE_W-1:0];
                REG_COLUMN_STEP: r_column_step <= i_cfg_data[STEP_W-1:0];
                REG_ROW_STEP:    r_row_step    <= i_cfg_data[STEP_W-1:0];
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col       <= '0;
            r_row       <= '0;
            r_in_run    <= 1'b0;
            r_run_start <= '0;
            r_s1_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (accept) begin
                r_col       <= n_col;
                r_row       <= n_row;
                r_in_run    <= n_in_run;
                r_run_start <= n_run_start;
            end
            if (accept) begin
                r_s1_valid <= emit;
            end else if (s1_move) begin
                r_s1_valid <= 1'b0;
            end
            if (out_ready) begin
                r_out_valid <= r_s1_valid;
            end
        end
    end

    // payload of the tracking stage, loaded only by a pixel that closes a run
    always_ff @(posedge i_clk) begin
        if (accept && emit) begin
            r_s1_row   <= r_row;
            r_s1_start <= box_start;
            r_s1_end   <= r_col;
            r_s1_edge  <= pix_set;
            r_s1_label <= i_pix.mask_label;
            r_s1_id    <= i_pix.mask_id;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s1_move) begin
            r_out.y_min     <= q_scale(SCALE_W'(r_s1_row), r_row_step);
            r_out.x_min     <= q_scale(SCALE_W'(r_s1_start), r_column_step);
            r_out.y_max     <= q_scale(SCALE_W'(r_s1_row) + SCALE_W'(1), r_row_step);
            r_out.x_max     <= r_s1_edge ? Q_ONE : q_scale(SCALE_W'(r_s1_end), r_column_step);
            r_out.box_label <= r_s1_label;
            r_out.box_id    <= r_s1_id;
        end
    end

    assign o_valid = r_out_valid;
    assign o_box   = r_out;

endmodule

>>> hw/rtl/mrrb_checker.sv
// port-level checks for the mask row run box extractor, bound to the top level
module mrrb_checker (
    input logic                  i_clk,
    input logic                  i_rst_n,
    input logic                  i_cfg_valid,
    input logic                  o_stall,
    input logic                  o_valid,
    input logic                  i_stall,
    input mrrb_pkg::t_box_beat   o_box,
    input logic                  o_cfg_ready
);
    import mrrb_pkg::*;

    // a box held under stall keeps its contents
    a_box_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid && $stable(o_box))
        else $error("box beat changed under stall");

    // intake only backs up when a box is waiting and stalled
    a_stall_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_stall |-> o_valid && i_stall)
        else $error("pixel stall without a stalled box");

    // bounds are ordered
    a_box_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_box.y_min <= o_box.y_max) && (o_box.x_min <= o_box.x_max))
        else $error("box bounds out of order");

    a_reset_idle: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid && !o_stall)
        else $error("box channel active after reset");

    a_cfg_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cfg_valid |-> o_cfg_ready)
        else $error("cfg channel not ready");

endmodule

bind mask_row_run_boxes mrrb_checker u_mrrb_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_cfg_valid (i_cfg_valid),
    .o_stall     (o_stall),
    .o_valid     (o_valid),
    .i_stall     (i_stall),
    .o_box       (o_box),
    .o_cfg_ready (o_cfg_ready)
);
